// ===== hw/rtl/acs_pkg.sv =====
// Shared types, codes and constants for the attribute cursor scanner.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package acs_pkg;

    // Buffer geometry
    localparam int STREAM_DEPTH = 256;
    localparam int ADDR_W       = $clog2(STREAM_DEPTH);
    localparam int BYTE_W       = 8;
    // Scan cursor: signed, room for a record skip past either end
    localparam int POS_W        = ADDR_W + 2;
    localparam int VAL_W        = 9;

    // Special bytes
    localparam logic [BYTE_W-1:0] REC_MARK   = 8'h7C;
    localparam logic [BYTE_W-1:0] STOP_M     = 8'h4D;
    localparam logic [BYTE_W-1:0] STOP_N     = 8'h4E;
    localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'h30;
    localparam logic [BYTE_W-1:0] OPEN_BIT   = 8'h80;

    // Mode bits in the mark attribute
    localparam logic [BYTE_W-1:0] MARK_SEG    = 8'h01;
    localparam logic [BYTE_W-1:0] MARK_STRESS = 8'h02;
    localparam logic [BYTE_W-1:0] MARK_EIGHT  = 8'h08;

    // Cursor steps
    localparam int REC_SKIP = 6;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [3:0]       delta_t;

    typedef enum logic [2:0] {
        CMD_LOAD_STREAM = 3'd0,
        CMD_LOAD_CLASS  = 3'd1,
        CMD_LOAD_MARK   = 3'd2,
        CMD_SEGMENT     = 3'd3,
        CMD_STRESS      = 3'd4,
        CMD_EIGHT_FWD   = 3'd5,
        CMD_EIGHT_BACK  = 3'd6,
        CMD_STRONG      = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_BYTE,
        ST_MARK,
        ST_CLASS,
        ST_DONE
    } state_t;

    // Table write port
    typedef struct packed {
        logic                we_stream;
        logic                we_class;
        logic                we_mark;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   data;
    } tbl_wr_t;

    // Table read addresses, one per memory
    typedef struct packed {
        logic [ADDR_W-1:0]   stream;
        logic [BYTE_W-1:0]   mark;
        logic [BYTE_W-1:0]   cls;
    } tbl_rd_t;

    // Flags from the cursor adder
    typedef struct packed {
        logic gt_lim;
        logic ge_lim;
        logic neg;
    } pos_flags_t;

    // Mark attribute bit tested by each scan mode
    function automatic logic [BYTE_W-1:0] mode_bit(input cmd_t cmd);
        logic [BYTE_W-1:0] b;
        case (cmd)
            CMD_STRESS:     b = MARK_STRESS;
            CMD_EIGHT_FWD:  b = MARK_EIGHT;
            CMD_EIGHT_BACK: b = MARK_EIGHT;
            default:        b = MARK_SEG;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/acs_tables.sv =====
// Stream buffer, class table and mark table, each one write and one
// registered read port. Depends on acs_pkg.
`timescale 1ns / 1ps

module acs_tables (
    input  logic                            aclk,
    input  acs_pkg::tbl_wr_t                wr,
    input  acs_pkg::tbl_rd_t                rd,
    output logic [acs_pkg::BYTE_W-1:0]      stream_rdata,
    output logic [acs_pkg::BYTE_W-1:0]      mark_rdata,
    output logic [acs_pkg::BYTE_W-1:0]      class_rdata
);
    import acs_pkg::*;

    logic [BYTE_W-1:0] stream_mem [STREAM_DEPTH];
    logic [BYTE_W-1:0] class_mem  [2**BYTE_W];
    logic [BYTE_W-1:0] mark_mem   [2**BYTE_W];

    // Writes from load commands
    always_ff @(posedge aclk) begin
        if (wr.we_stream) begin
            stream_mem[wr.addr] <= wr.data;
        end
        if (wr.we_class) begin
            class_mem[wr.addr] <= wr.data;
        end
        if (wr.we_mark) begin
            mark_mem[wr.addr] <= wr.data;
        end
    end

    // Registered reads
    always_ff @(posedge aclk) begin
        stream_rdata <= stream_mem[rd.stream];
        mark_rdata   <= mark_mem[rd.mark];
        class_rdata  <= class_mem[rd.cls];
    end

endmodule

// ===== hw/rtl/acs_pos_unit.sv =====
// Shared cursor adder: position plus a small signed step, with the
// limit and sign compares. Depends on acs_pkg.
`timescale 1ns / 1ps

module acs_pos_unit (
    input  acs_pkg::pos_t                   pos,
    input  acs_pkg::delta_t                 delta,
    input  logic [acs_pkg::ADDR_W-1:0]      limit,
    output acs_pkg::pos_t                   sum,
    output acs_pkg::pos_flags_t             flags
);
    import acs_pkg::*;

    pos_t lim_s;

    always_comb begin
        lim_s        = pos_t'({2'b00, limit});
        sum          = pos + pos_t'(delta);
        flags.gt_lim = (sum > lim_s);
        flags.ge_lim = (sum >= lim_s);
        flags.neg    = sum[POS_W-1];
    end

endmodule

// ===== hw/rtl/acs_seq.sv =====
// Scan sequencer: walks the buffer one byte at a time through the shared
// cursor adder and the table reads. Depends on acs_pkg, acs_pos_unit.
`timescale 1ns / 1ps

module acs_seq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  acs_pkg::cmd_t                   cmd,
    input  logic [acs_pkg::ADDR_W-1:0]      limit,
    input  logic signed [acs_pkg::ADDR_W:0] start_req,
    input  logic [acs_pkg::BYTE_W-1:0]      stream_rdata,
    input  logic [acs_pkg::BYTE_W-1:0]      mark_rdata,
    input  logic [acs_pkg::BYTE_W-1:0]      class_rdata,
    input  logic                            out_free,
    output acs_pkg::tbl_rd_t                rd,
    output logic                            idle,
    output logic                            res_valid,
    output logic signed [acs_pkg::VAL_W-1:0] res_val,
    output logic [acs_pkg::ADDR_W-1:0]      res_pos
);
    import acs_pkg::*;

    state_t                   state_reg, state_next;
    pos_t                     pos_reg, pos_next;
    logic [ADDR_W-1:0]        lim_reg, lim_next;
    cmd_t                     mode_reg, mode_next;
    logic [BYTE_W-1:0]        byte_reg, byte_next;
    logic signed [VAL_W-1:0]  val_reg, val_next;
    logic [ADDR_W-1:0]        fpos_reg, fpos_next;

    delta_t                   delta;
    pos_t                     sum;
    pos_flags_t               flags;
    logic                     back;
    logic                     hit;
    logic                     stop_byte;

    acs_pos_unit u_pos (
        .pos   (pos_reg),
        .delta (delta),
        .limit (lim_reg),
        .sum   (sum),
        .flags (flags)
    );

    // State and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        lim_reg  <= lim_next;
        mode_reg <= mode_next;
        byte_reg <= byte_next;
        val_reg  <= val_next;
        fpos_reg <= fpos_next;
    end

    // Next state, cursor step and table addressing
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        lim_next   = lim_reg;
        mode_next  = mode_reg;
        byte_next  = byte_reg;
        val_next   = val_reg;
        fpos_next  = fpos_reg;

        back      = (mode_reg == CMD_EIGHT_BACK);
        hit       = |(mark_rdata & mode_bit(mode_reg));
        stop_byte = (byte_reg == STOP_M) || (byte_reg == STOP_N);
        delta     = back ? -4'sd1 : 4'sd1;

        rd.stream = sum[ADDR_W-1:0];
        rd.mark   = stream_rdata;
        rd.cls    = byte_reg;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    pos_next   = pos_t'(start_req);
                    lim_next   = limit;
                    mode_next  = cmd;
                    state_next = ST_ADV;
                end
            end

            // Step the cursor; give up past the limit or below zero
            ST_ADV: begin
                if ((!back && flags.gt_lim) || (back && flags.neg)) begin
                    val_next   = '0;
                    fpos_next  = '0;
                    state_next = ST_DONE;
                end else begin
                    pos_next   = sum;
                    state_next = ST_BYTE;
                end
            end

            // Zero bytes are skipped, others look up their mark attribute
            ST_BYTE: begin
                byte_next  = stream_rdata;
                state_next = (stream_rdata == '0) ? ST_ADV : ST_MARK;
            end

            ST_MARK: begin
                if (hit) begin
                    if (mode_reg == CMD_STRESS) begin
                        val_next = $signed({1'b0, byte_reg}) - $signed({1'b0, DIGIT_BASE});
                    end else begin
                        val_next = $signed({1'b0, byte_reg});
                    end
                    fpos_next  = pos_reg[ADDR_W-1:0];
                    state_next = (mode_reg == CMD_STRONG) ? ST_CLASS : ST_DONE;
                end else if (byte_reg == REC_MARK) begin
                    // Jump over the record body
                    delta      = back ? -delta_t'(REC_SKIP) : delta_t'(REC_SKIP);
                    pos_next   = sum;
                    state_next = ST_ADV;
                end else begin
                    // End-of-segment checks per mode
                    delta = (mode_reg == CMD_EIGHT_FWD) ? 4'sd0 : 4'sd1;
                    if ((mode_reg == CMD_SEGMENT || mode_reg == CMD_STRONG)
                            && (flags.ge_lim || stop_byte)) begin
                        val_next   = '0;
                        fpos_next  = '0;
                        state_next = ST_DONE;
                    end else if ((mode_reg == CMD_STRESS || mode_reg == CMD_EIGHT_FWD)
                            && flags.ge_lim) begin
                        val_next   = '0;
                        fpos_next  = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_ADV;
                    end
                end
            end

            // Strong scan: keep going until the class attribute opens
            ST_CLASS: begin
                state_next = (|(class_rdata & OPEN_BIT)) ? ST_DONE : ST_ADV;
            end

            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_val   = val_reg;
    assign res_pos   = fpos_reg;

endmodule

// ===== hw/rtl/attribute_cursor_scanner.sv =====
// Attribute cursor scanner top level: stream handshake, load decode and
// result register. Depends on acs_pkg, acs_tables, acs_seq.
// Load words are written straight into the tables. A scan reads the stream byte at
// each cursor step, then the mark attribute of a non-zero byte (a record mark jumps
// over the record body), and for a strong scan the class attribute of the hit byte.
// One word in flight at a time. Sync active-low reset clears control, not the tables.
`timescale 1ns / 1ps

module attribute_cursor_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] address, [15:8] write_data, [23:16] limit, [32:24] start_req
    input  logic [39:0] s_tdata,
    // [2:0] command
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [8:0] found_value, [16:9] found_position
    output logic [23:0] m_tdata
);
    import acs_pkg::*;

    logic                     s_accept;
    cmd_t                     s_cmd;
    logic                     is_scan;
    tbl_wr_t                  wr;
    tbl_rd_t                  rd;
    logic [BYTE_W-1:0]        stream_rdata;
    logic [BYTE_W-1:0]        mark_rdata;
    logic [BYTE_W-1:0]        class_rdata;
    logic                     idle;
    logic                     out_free;
    logic                     res_valid;
    logic signed [VAL_W-1:0]  res_val;
    logic [ADDR_W-1:0]        res_pos;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [23:0]              m_tdata_reg, m_tdata_next;

    // Input handshake and load decode
    assign s_tready = idle;
    assign s_accept = s_tvalid && s_tready;
    assign s_cmd    = cmd_t'(s_tuser);
    assign is_scan  = !(s_cmd == CMD_LOAD_STREAM || s_cmd == CMD_LOAD_CLASS
                        || s_cmd == CMD_LOAD_MARK);

    always_comb begin
        wr.we_stream = s_accept && (s_cmd == CMD_LOAD_STREAM);
        wr.we_class  = s_accept && (s_cmd == CMD_LOAD_CLASS);
        wr.we_mark   = s_accept && (s_cmd == CMD_LOAD_MARK);
        wr.addr      = s_tdata[7:0];
        wr.data      = s_tdata[15:8];
    end

    acs_tables u_tables (
        .aclk         (aclk),
        .wr           (wr),
        .rd           (rd),
        .stream_rdata (stream_rdata),
        .mark_rdata   (mark_rdata),
        .class_rdata  (class_rdata)
    );

    acs_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (s_accept && is_scan),
        .cmd          (s_cmd),
        .limit        (s_tdata[23:16]),
        .start_req    ($signed(s_tdata[32:24])),
        .stream_rdata (stream_rdata),
        .mark_rdata   (mark_rdata),
        .class_rdata  (class_rdata),
        .out_free     (out_free),
        .rd           (rd),
        .idle         (idle),
        .res_valid    (res_valid),
        .res_val      (res_val),
        .res_pos      (res_pos)
    );

    // Result register
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'b0, res_pos, res_val};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
